@@ rtl/tcc_pkg.sv @@
// Shared types and constants for the text console character writer.
// Holds the command record passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int COLS_DEF       = 80;
    localparam int ROWS_DEF       = 25;
    localparam int FIFO_DEPTH_DEF = 2;
    localparam int TAB_STOP       = 8;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    localparam logic [7:0]  CH_BS        = 8'h08;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_LF        = 8'h0A;
    localparam logic [7:0]  CH_CR        = 8'h0D;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_DEL       = 8'h7F;
    localparam logic [3:0]  FORE_WHITE   = 4'hF;
    localparam logic [15:0] SCROLL_BLANK = 16'h0F20;

    typedef enum logic [1:0] {
        OP_PUT        = 2'd0,
        OP_CLEAR      = 2'd1,
        OP_SET_CURSOR = 2'd2,
        OP_READ_CELL  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_GLYPH,
        CMD_BACKSPACE,
        CMD_TAB,
        CMD_CR,
        CMD_LF,
        CMD_CLEAR,
        CMD_SET_CURSOR,
        CMD_READ_CELL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] data_word;
        logic [6:0]  col;
        logic [4:0]  row;
        logic        in_range;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL_COPY,
        ST_FILL
    } back_state_t;

endpackage

@@ rtl/tcc_front.sv @@
// Front end: accepts input transactions and classifies them into commands.
// Precomputes cell words, saturated cursor targets and read range checks.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_front #(
    parameter int COLS = tcc_pkg::COLS_DEF,
    parameter int ROWS = tcc_pkg::ROWS_DEF
) (
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    op,
    input  logic [7:0]    char_code,
    input  logic [3:0]    bg_color,
    input  logic [3:0]    fg_color,
    input  logic [6:0]    target_col,
    input  logic [4:0]    target_row,
    input  logic          fifo_full,
    output logic          push,
    output tcc_pkg::cmd_t cmd
);
    import tcc_pkg::*;

    logic col_ok;
    logic row_ok;

    assign s_ready = !fifo_full;
    assign push    = s_valid && s_ready;
    assign col_ok  = int'(target_col) < COLS;
    assign row_ok  = int'(target_row) < ROWS;

    always_comb begin
        cmd.kind      = CMD_NOP;
        cmd.data_word = {bg_color, fg_color, char_code};
        cmd.col       = col_ok ? target_col : 7'(COLS - 1);
        cmd.row       = row_ok ? target_row : 5'(ROWS - 1);
        cmd.in_range  = col_ok && row_ok;
        case (op_t'(op))
            OP_PUT: begin
                if (char_code == CH_BS) begin
                    cmd.kind = CMD_BACKSPACE;
                end else if (char_code == CH_TAB) begin
                    cmd.kind = CMD_TAB;
                end else if (char_code == CH_CR) begin
                    cmd.kind = CMD_CR;
                end else if (char_code == CH_LF) begin
                    cmd.kind = CMD_LF;
                end else if (char_code >= CH_SPACE && char_code <= CH_DEL) begin
                    cmd.kind = CMD_GLYPH;
                end
            end
            OP_CLEAR: begin
                cmd.kind      = CMD_CLEAR;
                cmd.data_word = {bg_color, FORE_WHITE, CH_SPACE};
            end
            OP_SET_CURSOR: begin
                cmd.kind = CMD_SET_CURSOR;
            end
            OP_READ_CELL: begin
                cmd.kind = CMD_READ_CELL;
            end
            default: begin
                cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

@@ rtl/tcc_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
// Lets either side stall on its own.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_cmd_fifo #(
    parameter int DEPTH = tcc_pkg::FIFO_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tcc_pkg::cmd_t cmd_in,
    output logic          full,
    input  logic          pop,
    output tcc_pkg::cmd_t cmd_out,
    output logic          empty
);
    import tcc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign cmd_out = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ rtl/tcc_back.sv @@
// Back end: cursor, screen memory, scroll/clear sequencer and result register.
// Executes commands taken from the command queue.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_back #(
    parameter int COLS = tcc_pkg::COLS_DEF,
    parameter int ROWS = tcc_pkg::ROWS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    input  tcc_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [6:0]    cursor_column,
    output logic [4:0]    cursor_line,
    output logic [10:0]   cursor_offset,
    output logic [15:0]   cell_data
);
    import tcc_pkg::*;

    localparam int CELLS  = COLS * ROWS;
    localparam int COPY_N = (ROWS - 1) * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SCAN_W = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CW     = COL_W + 1;

    back_state_t       state_reg, state_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [15:0]       fill_data_reg, fill_data_next;
    logic              read_ok_reg, read_ok_next;
    logic              m_valid_reg, m_valid_next;
    logic [6:0]        out_col_reg, out_col_next;
    logic [4:0]        out_row_reg, out_row_next;
    logic [10:0]       out_off_reg, out_off_next;
    logic [15:0]       out_cell_reg, out_cell_next;

    logic [15:0]       cells_mem [CELLS];
    logic [15:0]       rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              out_free;
    logic              out_load;
    logic              scan_end;
    logic              copy_done;
    logic [ADDR_W-1:0] cur_addr;
    logic [CW-1:0]     col_ext;
    logic [CW-1:0]     col_calc;
    logic              row_adv;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    logic              put_scroll;
    logic              is_put;

    assign out_free  = !m_valid_reg || m_ready;
    assign scan_end  = scan_reg == SCAN_W'(CELLS - 1);
    assign copy_done = (scan_reg == SCAN_W'(COPY_N)) && !wr_pend_reg;
    assign cur_addr  = ADDR_W'(int'(cur_row_reg) * COLS + int'(cur_col_reg));
    assign col_ext   = {1'b0, cur_col_reg};
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid && out_free;
    assign is_put    = cmd.kind == CMD_GLYPH || cmd.kind == CMD_BACKSPACE ||
                       cmd.kind == CMD_TAB || cmd.kind == CMD_CR ||
                       cmd.kind == CMD_LF || cmd.kind == CMD_NOP;

    // cursor motion of a put
    always_comb begin
        col_calc = col_ext;
        row_adv  = 1'b0;
        case (cmd.kind)
            CMD_GLYPH: begin
                col_calc = col_ext + 1'b1;
            end
            CMD_BACKSPACE: begin
                if (cur_col_reg != '0) begin
                    col_calc = col_ext - 1'b1;
                end
            end
            CMD_TAB: begin
                col_calc = (col_ext + CW'(TAB_STOP)) & ~CW'(TAB_STOP - 1);
            end
            CMD_CR: begin
                col_calc = '0;
            end
            CMD_LF: begin
                col_calc = '0;
                row_adv  = 1'b1;
            end
            default: begin
                col_calc = col_ext;
            end
        endcase
        if (col_calc >= CW'(COLS)) begin
            col_calc = '0;
            row_adv  = 1'b1;
        end
        put_col    = col_calc[COL_W-1:0];
        put_row    = cur_row_reg;
        put_scroll = 1'b0;
        if (row_adv) begin
            if (cur_row_reg == ROW_W'(ROWS - 1)) begin
                put_scroll = 1'b1;
            end else begin
                put_row = cur_row_reg + 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (scan_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd_pop) begin
                    if (cmd.kind == CMD_CLEAR) begin
                        state_next = ST_FILL;
                    end else if (cmd.kind == CMD_READ_CELL) begin
                        state_next = ST_READ;
                    end else if (is_put && put_scroll) begin
                        state_next = ST_SCROLL_COPY;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_IDLE;
            end
            ST_SCROLL_COPY: begin
                if (copy_done) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (scan_end) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        scan_next      = scan_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        fill_data_next = fill_data_reg;
        read_ok_next   = read_ok_reg;
        mem_we         = 1'b0;
        mem_waddr      = scan_reg[ADDR_W-1:0];
        mem_wdata      = fill_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = ADDR_W'(scan_reg + SCAN_W'(COLS));
        out_load       = 1'b0;
        out_cell_next  = '0;
        case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                scan_next = scan_end ? '0 : scan_reg + 1'b1;
            end
            ST_IDLE: begin
                if (cmd_pop) begin
                    case (cmd.kind)
                        CMD_CLEAR: begin
                            cur_col_next   = '0;
                            cur_row_next   = '0;
                            scan_next      = '0;
                            fill_data_next = cmd.data_word;
                        end
                        CMD_SET_CURSOR: begin
                            cur_col_next = COL_W'(cmd.col);
                            cur_row_next = ROW_W'(cmd.row);
                            out_load     = 1'b1;
                        end
                        CMD_READ_CELL: begin
                            mem_re       = cmd.in_range;
                            mem_raddr    = ADDR_W'(int'(cmd.row) * COLS + int'(cmd.col));
                            read_ok_next = cmd.in_range;
                        end
                        default: begin
                            cur_col_next = put_col;
                            cur_row_next = put_row;
                            if (cmd.kind == CMD_GLYPH) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = cmd.data_word;
                            end
                            if (put_scroll) begin
                                scan_next = '0;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                out_load      = 1'b1;
                out_cell_next = read_ok_reg ? rdata_reg : '0;
            end
            ST_SCROLL_COPY: begin
                if (scan_reg != SCAN_W'(COPY_N)) begin
                    mem_re       = 1'b1;
                    wr_pend_next = 1'b1;
                    wr_addr_next = scan_reg[ADDR_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                if (wr_pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = rdata_reg;
                end
                if (copy_done) begin
                    fill_data_next = SCROLL_BLANK;
                end
            end
            ST_FILL: begin
                mem_we = 1'b1;
                if (scan_end) begin
                    scan_next = '0;
                    out_load  = 1'b1;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        out_col_next = 7'(cur_col_next);
        out_row_next = 5'(cur_row_next);
        out_off_next = 11'(int'(cur_row_next) * COLS + int'(cur_col_next));
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            scan_reg    <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            scan_reg    <= scan_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg   <= wr_addr_next;
        fill_data_reg <= fill_data_next;
        read_ok_reg   <= read_ok_next;
        if (out_load) begin
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_off_reg  <= out_off_next;
            out_cell_reg <= out_cell_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= cells_mem[mem_raddr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign cursor_column = out_col_reg;
    assign cursor_line   = out_row_reg;
    assign cursor_offset = out_off_reg;
    assign cell_data     = out_cell_reg;

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cur_col_reg) < COLS && int'(cur_row_reg) < ROWS)
        else $error("cursor left the screen");

    a_no_pop_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INIT |-> !cmd_pop)
        else $error("command taken during reset sweep");

    a_pop_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (!m_valid_reg || m_ready))
        else $error("command taken with result slot occupied");

    a_copy_write_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_pend_reg |-> state_reg == ST_SCROLL_COPY)
        else $error("scroll write outside copy phase");

    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> m_valid_reg)
        else $error("read cell gave no result");

endmodule

@@ rtl/text_console_char_writer.sv @@
// Text console character writer, top level.
//
// Input channel s_axis_*: one transaction per operation; tuser carries the
// operation (put character, clear screen, set cursor, read cell), tdata its
// operands. Result channel m_axis_*: exactly one transaction per operation
// with the cursor after it and, for read cell, the cell word (zero otherwise).
// A put or set cursor loads the result register as it is taken from the queue,
// a read cell from ST_READ after its registered memory read; puts can follow at
// one per cycle while the receiver takes the results. A clear walks the whole
// screen memory before its result. A put that scrolls copies (ROWS-1)*COLS cells
// with one read and one write per cycle and blanks the bottom line before its result.
// A command queue of FIFO_DEPTH entries keeps accepting while the back end
// works or the result waits; s_axis_tready drops when it is full.
// Reset: aresetn low clears the cursor and then a sweep over all COLS*ROWS cells
// zeroes the screen; queued commands wait until it ends.
// A stalled receiver holds the result register and, once the queue fills,
// the input channel.
// Depends on tcc_pkg, tcc_front, tcc_cmd_fifo, tcc_back.
`timescale 1ns / 1ps

module text_console_char_writer #(
    parameter int COLS       = tcc_pkg::COLS_DEF,
    parameter int ROWS       = tcc_pkg::ROWS_DEF,
    parameter int FIFO_DEPTH = tcc_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // char_code[7:0], bg_color[11:8], fg_color[15:12],
    // target_col[22:16], target_row[27:23], zero[31:28]
    input  logic [tcc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op[1:0]
    input  logic [tcc_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cursor_column[6:0], cursor_line[11:7], cursor_offset[22:12],
    // cell_data[38:23], zero[39]
    output logic [tcc_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import tcc_pkg::*;

    cmd_t        front_cmd;
    cmd_t        queue_cmd;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_line;
    logic [10:0] cursor_offset;
    logic [15:0] cell_data;

    tcc_front #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_front (
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .op         (s_axis_tuser[1:0]),
        .char_code  (s_axis_tdata[7:0]),
        .bg_color   (s_axis_tdata[11:8]),
        .fg_color   (s_axis_tdata[15:12]),
        .target_col (s_axis_tdata[22:16]),
        .target_row (s_axis_tdata[27:23]),
        .fifo_full  (full),
        .push       (push),
        .cmd        (front_cmd)
    );

    tcc_cmd_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .cmd_in  (front_cmd),
        .full    (full),
        .pop     (pop),
        .cmd_out (queue_cmd),
        .empty   (empty)
    );

    tcc_back #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (!empty),
        .cmd           (queue_cmd),
        .cmd_pop       (pop),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .cursor_column (cursor_column),
        .cursor_line   (cursor_line),
        .cursor_offset (cursor_offset),
        .cell_data     (cell_data)
    );

    assign m_axis_tdata = {1'b0, cell_data, cursor_offset, cursor_line, cursor_column};

endmodule

@@ dv/console_report_checker.sv @@
// Report checker for the text console character writer.
// Tracks screen memory and cursor from accepted commands and compares each result transaction.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module console_report_checker #(
    parameter int COLS = tcc_pkg::COLS_DEF,
    parameter int ROWS = tcc_pkg::ROWS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    // char_code[7:0], bg_color[11:8], fg_color[15:12],
    // target_col[22:16], target_row[27:23], zero[31:28]
    input  logic [tcc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op[1:0]
    input  logic [tcc_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // cursor_column[6:0], cursor_line[11:7], cursor_offset[22:12],
    // cell_data[38:23], zero[39]
    input  logic [tcc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output int                            mismatches,
    output int                            open_reports
);
    import tcc_pkg::*;

    localparam int CELLS = COLS * ROWS;

    typedef struct packed {
        logic [3:0] reserved;
        logic [4:0] target_row;
        logic [6:0] target_col;
        logic [3:0] fg_color;
        logic [3:0] bg_color;
        logic [7:0] char_code;
        logic [1:0] op;
    } console_cmd_t;

    typedef struct packed {
        logic        reserved;
        logic [15:0] cell_data;
        logic [10:0] cursor_offset;
        logic [4:0]  cursor_line;
        logic [6:0]  cursor_column;
    } cursor_report_t;

    logic [15:0]    screen [CELLS];
    int             cur_col;
    int             cur_row;
    cursor_report_t report_q [$];

    function automatic cursor_report_t run_console_op(console_cmd_t cmd);
        cursor_report_t rep;
        logic [15:0]    cell_word;
        cell_word = '0;
        if (cmd.op == OP_PUT) begin
            if (cmd.char_code == CH_BS && cur_col != 0) begin
                cur_col--;
            end else if (cmd.char_code == CH_TAB) begin
                cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
            end else if (cmd.char_code == CH_CR) begin
                cur_col = 0;
            end else if (cmd.char_code == CH_LF) begin
                cur_col = 0;
                cur_row++;
            end else if (cmd.char_code >= CH_SPACE && cmd.char_code <= CH_DEL) begin
                screen[cur_row * COLS + cur_col] = {cmd.bg_color, cmd.fg_color,
                                                    cmd.char_code};
                cur_col++;
            end
            if (cur_col >= COLS) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= ROWS) begin
                for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
                    screen[i] = screen[i + COLS];
                end
                for (int i = (ROWS - 1) * COLS; i < CELLS; i++) begin
                    screen[i] = SCROLL_BLANK;
                end
                cur_row = ROWS - 1;
            end
        end else if (cmd.op == OP_CLEAR) begin
            for (int i = 0; i < CELLS; i++) begin
                screen[i] = {cmd.bg_color, FORE_WHITE, CH_SPACE};
            end
            cur_col = 0;
            cur_row = 0;
        end else if (cmd.op == OP_SET_CURSOR) begin
            cur_col = (cmd.target_col >= COLS) ? COLS - 1 : int'(cmd.target_col);
            cur_row = (cmd.target_row >= ROWS) ? ROWS - 1 : int'(cmd.target_row);
        end else begin
            if (cmd.target_col < COLS && cmd.target_row < ROWS) begin
                cell_word = screen[cmd.target_row * COLS + cmd.target_col];
            end
        end
        rep.reserved      = 1'b0;
        rep.cell_data     = cell_word;
        rep.cursor_offset = 11'(cur_row * COLS + cur_col);
        rep.cursor_line   = 5'(cur_row);
        rep.cursor_column = 7'(cur_col);
        return rep;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        cursor_report_t want;
        cursor_report_t got;
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) begin
                screen[i] = '0;
            end
            cur_col    = 0;
            cur_row    = 0;
            mismatches = 0;
            report_q.delete();
        end else begin
            // retire before adding: a result never answers the command of the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (report_q.size() == 0) begin
                    $error("result transaction 0x%0h with no command outstanding", got);
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    check_field("cursor_column", 16'(want.cursor_column),
                                16'(got.cursor_column));
                    check_field("cursor_line", 16'(want.cursor_line), 16'(got.cursor_line));
                    check_field("cursor_offset", 16'(want.cursor_offset),
                                16'(got.cursor_offset));
                    check_field("cell_data", want.cell_data, got.cell_data);
                    check_field("reserved", 16'(want.reserved), 16'(got.reserved));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                report_q.push_back(run_console_op(console_cmd_t'({s_axis_tdata,
                                                                  s_axis_tuser})));
            end
        end
        open_reports <= report_q.size();
    end

endmodule

@@ dv/text_console_char_writer_tb.sv @@
// Testbench top for the text console character writer.
// Drives command transactions under several idle and stall mixes; console_report_checker
// judges the results. Depends on tcc_pkg, text_console_char_writer, console_report_checker.
`timescale 1ns / 1ps

module text_console_char_writer_tb;
    import tcc_pkg::*;

    localparam int RANDOM_ITEMS    = 1650;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 10000;
    localparam int CMD_W           = S_TDATA_W + S_TUSER_W;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int   mismatches;
    int   open_reports;
    int   items_sent   = 0;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    logic hold_off_req = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    text_console_char_writer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    console_report_checker report_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .open_reports  (open_reports)
    );

    function automatic logic [CMD_W-1:0] console_word(logic [1:0] op, logic [7:0] ch,
                                                      logic [3:0] back, logic [3:0] fore,
                                                      logic [6:0] col, logic [4:0] row);
        return {4'b0000, row, col, fore, back, ch, op};
    endfunction

    function automatic logic [7:0] text_char();
        int pick;
        int code;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            code = $urandom_range(32, 127);
        end else if (pick < 95) begin
            case ($urandom_range(0, 3))
                0: return CH_BS;
                1: return CH_TAB;
                2: return CH_CR;
                default: return CH_LF;
            endcase
        end else if (pick < 98) begin
            code = $urandom_range(0, 31);
        end else begin
            code = $urandom_range(128, 255);
        end
        return code[7:0];
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] word);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_axis_tdata  <= word[CMD_W-1:S_TUSER_W];
        s_axis_tuser  <= word[S_TUSER_W-1:0];
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (open_reports != 0);
    endtask

    task automatic type_text(input int col, input int row, input int count);
        logic [31:0] rnd;
        rnd = $urandom;
        send_word(console_word(OP_SET_CURSOR, rnd[7:0], rnd[11:8], rnd[15:12],
                               col[6:0], row[4:0]));
        repeat (count) begin
            rnd = $urandom;
            send_word(console_word(OP_PUT, text_char(), rnd[3:0], rnd[7:4],
                                   rnd[14:8], rnd[19:15]));
        end
        if ($urandom_range(0, 1) == 1) begin
            rnd = $urandom;
            send_word(console_word(OP_PUT, CH_LF, rnd[3:0], rnd[7:4], rnd[14:8], rnd[19:15]));
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int          phase_end;
        int          pick;
        int          rc;
        int          rr;
        logic [31:0] rnd;
        logic [29:0] noise_bits;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(console_word(OP_PUT, 8'h41, 4'h0, 4'hF, 7'd0, 5'd0));
        send_word(console_word(OP_PUT, CH_DEL, 4'hF, 4'h0, 7'd127, 5'd31));
        send_word(console_word(OP_PUT, CH_SPACE, 4'h5, 4'hA, 7'd0, 5'd0));
        send_word(console_word(OP_READ_CELL, 8'hFF, 4'hF, 4'hF, 7'd0, 5'd0));
        send_word(console_word(OP_PUT, CH_BS, 4'h0, 4'h0, 7'd0, 5'd0));
        send_word(console_word(OP_PUT, CH_TAB, 4'h0, 4'h0, 7'd0, 5'd0));
        send_word(console_word(OP_PUT, CH_CR, 4'h0, 4'h0, 7'd0, 5'd0));
        send_word(console_word(OP_PUT, CH_BS, 4'h0, 4'h0, 7'd0, 5'd0));
        send_word(console_word(OP_PUT, 8'h80, 4'h3, 4'h3, 7'd0, 5'd0));
        send_word(console_word(OP_PUT, 8'hFF, 4'hF, 4'hF, 7'd0, 5'd0));
        send_word(console_word(OP_PUT, 8'h1F, 4'h1, 4'h2, 7'd0, 5'd0));
        send_word(console_word(OP_PUT, CH_LF, 4'h0, 4'h0, 7'd0, 5'd0));
        send_word(console_word(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 7'd79, 5'd0));
        send_word(console_word(OP_PUT, 8'h5A, 4'h2, 4'hE, 7'd0, 5'd0));
        send_word(console_word(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 7'd75, 5'd5));
        send_word(console_word(OP_PUT, CH_TAB, 4'h0, 4'h0, 7'd0, 5'd0));
        send_word(console_word(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 7'd127, 5'd31));
        send_word(console_word(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd80, 5'd0));
        send_word(console_word(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd0, 5'd25));
        send_word(console_word(OP_PUT, 8'h78, 4'h9, 4'h6, 7'd0, 5'd0));
        send_word(console_word(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd79, 5'd23));
        send_word(console_word(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd0, 5'd24));
        send_word(console_word(OP_PUT, CH_LF, 4'h0, 4'h0, 7'd0, 5'd0));
        send_word(console_word(OP_CLEAR, 8'h00, 4'hA, 4'h0, 7'd0, 5'd0));
        send_word(console_word(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd40, 5'd12));
        send_word(console_word(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 7'd127, 5'd31));
        drain_reports();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            if (p == 0 || p == 2) begin
                // back up the result path until the input stalls
                hold_off_req = 1'b1;
                type_text($urandom_range(0, 79), $urandom_range(0, 23), 16);
            end
            phase_end = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    rr = ($urandom_range(0, 9) == 0) ? 24 : $urandom_range(0, 23);
                    type_text($urandom_range(0, 79), rr, $urandom_range(1, 24));
                end else if (pick < 80) begin
                    repeat ($urandom_range(1, 6)) begin
                        rnd = $urandom;
                        if ($urandom_range(0, 9) == 0) begin
                            rc = $urandom_range(0, 127);
                            rr = $urandom_range(0, 31);
                        end else begin
                            rc = $urandom_range(0, 79);
                            rr = $urandom_range(0, 24);
                        end
                        send_word(console_word(OP_READ_CELL, rnd[7:0], rnd[11:8], rnd[15:12],
                                               rc[6:0], rr[4:0]));
                    end
                end else if (pick < 83) begin
                    rnd = $urandom;
                    send_word(console_word(OP_CLEAR, rnd[7:0], rnd[11:8], rnd[15:12],
                                           rnd[22:16], rnd[27:23]));
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        noise_bits = $urandom;
                        send_word({4'b0000, noise_bits});
                    end
                end
            end
            drain_reports();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && open_reports == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
